/* rtl/ctau_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar time arithmetic package
// Shared constants, codes, result type and calendar table functions.
// ----------------------------------------------------------------------------
package ctau_pkg;

  // Year table: entries 0 up to Years - 1 are the years from 1990 on.
  localparam int YearEntries = 52;
  localparam int Years       = YearEntries - 1;
  localparam int YidxW       = $clog2(Years + 1);

  // Command codes.
  localparam logic [1:0] CmdCount  = 2'd0;
  localparam logic [1:0] CmdToDate = 2'd1;
  localparam logic [1:0] CmdAdd    = 2'd2;
  localparam logic [1:0] CmdSub    = 2'd3;

  // Unit codes.
  localparam logic [2:0] UnitSec   = 3'd0;
  localparam logic [2:0] UnitMin   = 3'd1;
  localparam logic [2:0] UnitHour  = 3'd2;
  localparam logic [2:0] UnitDay   = 3'd3;
  localparam logic [2:0] UnitMonth = 3'd4;

  // Reciprocal for the day split: (x >> 7) / 675 for a 32-bit x.
  localparam logic [25:0] RecipDay   = 26'd50903317;
  localparam int          RecipDaySh = 35;
  // Reciprocal for the hour split of a 17-bit remainder.
  localparam logic [17:0] RecipHour   = 18'd149131;
  localparam int          RecipHourSh = 29;
  // Reciprocal for the minute split of a 12-bit remainder.
  localparam logic [14:0] RecipMin   = 15'd17477;
  localparam int          RecipMinSh = 20;

  localparam logic [8:0] DaysBefore [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] count;
    logic        oor;
  } result_t;

  // Last day count of table year i (year 1990 + i).
  function automatic logic [15:0] year_end(input int i);
    return 16'(365 * (i + 1) + ((1990 + i) >> 2) - 497);
  endfunction

  // Two-digit form of table year i.
  function automatic logic [6:0] year_two_digit(input int i);
    return 7'((1990 + i) % 100);
  endfunction

  // Days before month k (0 is January) in a normal or leap year.
  function automatic logic [8:0] month_start(input int k, input logic leap);
    return DaysBefore[k] + 9'((leap && k >= 2) ? 1 : 0);
  endfunction

endpackage

/* rtl/ctau_front.sv */
// ----------------------------------------------------------------------------
// Calendar front end
// Input register, day count, counts per unit, interval and direct results.
// ----------------------------------------------------------------------------
module ctau_front import ctau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [2:0]  unit_i,
  input  logic [31:0] amount_i,
  output logic        valid_o,
  output logic        use_conv_o,
  output logic [31:0] total_o,
  output result_t     res_o
);

  // Input register.
  logic        v0_q;
  logic [1:0]  cmd0_q;
  logic [6:0]  y0_q;
  logic [3:0]  m0_q;
  logic [4:0]  d0_q;
  logic [4:0]  h0_q;
  logic [5:0]  mi0_q;
  logic [5:0]  s0_q;
  logic [2:0]  unit0_q;
  logic [31:0] amt0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd0_q  <= cmd_i;
      y0_q    <= year_i;
      m0_q    <= month_i;
      d0_q    <= day_i;
      h0_q    <= hour_i;
      mi0_q   <= minute_i;
      s0_q    <= second_i;
      unit0_q <= unit_i;
      amt0_q  <= amount_i;
    end
  end

  // Stage 1: day count, time of day, interval in seconds, month step.
  logic [7:0]  yy;
  logic [8:0]  dbm;
  logic [31:0] dn_full;
  logic [15:0] dn_d;
  logic [16:0] hms_d;
  logic [16:0] mult_k;
  logic [31:0] step_d;
  logic [10:0] mc_d;
  result_t     mres_d;

  always_comb begin
    yy  = 8'(y0_q) + 8'd8;
    dbm = '0;
    if (m0_q >= 4'd1 && m0_q <= 4'd12) begin
      dbm = DaysBefore[4'(m0_q - 4'd1)];
    end
    dn_full = 32'd731 + 32'(yy) * 32'd365 + 32'(yy >> 2) + 32'(dbm) + 32'(d0_q);
    if (y0_q[1:0] == 2'd0 && m0_q < 4'd3) begin
      dn_full = dn_full - 32'd1;
    end
    dn_d  = dn_full[15:0];
    hms_d = 17'(h0_q) * 17'd3600 + 17'(mi0_q) * 17'd60 + 17'(s0_q);
    mc_d  = (11'(y0_q) + 11'd10) * 11'd12 + 11'(m0_q);

    case (unit0_q)
      UnitSec:  mult_k = 17'd1;
      UnitMin:  mult_k = 17'd60;
      UnitHour: mult_k = 17'd3600;
      UnitDay:  mult_k = 17'd86400;
      default:  mult_k = 17'd0;
    endcase
    step_d = amt0_q * 32'(mult_k);

    // One month forward or back with year wrap; day and time pass through.
    mres_d        = '0;
    mres_d.year   = y0_q;
    mres_d.day    = d0_q;
    mres_d.hour   = h0_q;
    mres_d.minute = mi0_q;
    mres_d.second = s0_q;
    if (cmd0_q == CmdAdd) begin
      if (m0_q >= 4'd12) begin
        mres_d.month = 4'd1;
        mres_d.year  = y0_q + 7'd1;
      end else begin
        mres_d.month = m0_q + 4'd1;
      end
    end else begin
      if (m0_q <= 4'd1) begin
        mres_d.month = 4'd12;
        mres_d.year  = y0_q - 7'd1;
      end else begin
        mres_d.month = m0_q - 4'd1;
      end
    end
  end

  logic        v1_q;
  logic [1:0]  cmd1_q;
  logic [2:0]  unit1_q;
  logic [15:0] dn1_q;
  logic [4:0]  h1_q;
  logic [5:0]  mi1_q;
  logic [16:0] hms1_q;
  logic [31:0] step1_q;
  logic [31:0] amt1_q;
  logic [10:0] mc1_q;
  result_t     mres1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q  <= cmd0_q;
    unit1_q <= unit0_q;
    dn1_q   <= dn_d;
    h1_q    <= h0_q;
    mi1_q   <= mi0_q;
    hms1_q  <= hms_d;
    step1_q <= step_d;
    amt1_q  <= amt0_q;
    mc1_q   <= mc_d;
    mres1_q <= mres_d;
  end

  // Stage 2: seconds, minutes and hours since the epoch.
  logic [31:0] secs_d;
  logic [31:0] mins_d;
  logic [31:0] hrs_d;

  always_comb begin
    secs_d = 32'(dn1_q) * 32'd86400 + 32'(hms1_q);
    mins_d = 32'(dn1_q) * 32'd1440 + 32'(h1_q) * 32'd60 + 32'(mi1_q);
    hrs_d  = 32'(dn1_q) * 32'd24 + 32'(h1_q);
  end

  logic        v2_q;
  logic [1:0]  cmd2_q;
  logic [2:0]  unit2_q;
  logic [15:0] dn2_q;
  logic [31:0] secs2_q;
  logic [31:0] mins2_q;
  logic [31:0] hrs2_q;
  logic [31:0] step2_q;
  logic [31:0] amt2_q;
  logic [10:0] mc2_q;
  result_t     mres2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q  <= cmd1_q;
    unit2_q <= unit1_q;
    dn2_q   <= dn1_q;
    secs2_q <= secs_d;
    mins2_q <= mins_d;
    hrs2_q  <= hrs_d;
    step2_q <= step1_q;
    amt2_q  <= amt1_q;
    mc2_q   <= mc1_q;
    mres2_q <= mres1_q;
  end

  // Stage 3: pick the count, the seconds total and the result path.
  logic [31:0] cnt;
  logic [31:0] total_d;
  logic        use_conv_d;
  result_t     res_d;

  always_comb begin
    case (unit2_q)
      UnitSec:   cnt = secs2_q;
      UnitMin:   cnt = mins2_q;
      UnitHour:  cnt = hrs2_q;
      UnitMonth: cnt = 32'(mc2_q);
      default:   cnt = 32'(dn2_q);
    endcase

    case (cmd2_q)
      CmdToDate: total_d = amt2_q;
      CmdAdd:    total_d = secs2_q + step2_q;
      CmdSub:    total_d = secs2_q - step2_q;
      default:   total_d = secs2_q;
    endcase

    use_conv_d = (cmd2_q == CmdToDate) ||
                 ((cmd2_q == CmdAdd || cmd2_q == CmdSub) && unit2_q != UnitMonth);

    if (cmd2_q == CmdCount) begin
      res_d       = '0;
      res_d.count = cnt;
    end else begin
      res_d = mres2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    use_conv_o <= use_conv_d;
    total_o    <= total_d;
    res_o      <= res_d;
  end

endmodule

/* rtl/ctau_div.sv */
// ----------------------------------------------------------------------------
// Calendar day split
// Splits a seconds total into whole days and seconds of the day.
// ----------------------------------------------------------------------------
module ctau_div import ctau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        use_conv_i,
  input  logic [31:0] total_i,
  input  result_t     res_i,
  output logic        valid_o,
  output logic        use_conv_o,
  output logic [15:0] days_o,
  output logic [16:0] rsec_o,
  output result_t     res_o
);

  // Reciprocal product of the total divided by 128.
  logic        v_q;
  logic        uc_q;
  logic [50:0] prod_q;
  logic [24:0] hi_q;
  logic [6:0]  lo_q;
  result_t     res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    uc_q   <= use_conv_i;
    prod_q <= 51'(total_i[31:7]) * 51'(RecipDay);
    hi_q   <= total_i[31:7];
    lo_q   <= total_i[6:0];
    res_q  <= res_i;
  end

  // Whole days and the remainder.
  logic [15:0] days_d;
  logic [9:0]  rem_d;

  always_comb begin
    days_d = 16'(prod_q >> RecipDaySh);
    rem_d  = 10'(hi_q - 25'(days_d) * 25'd675);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    use_conv_o <= uc_q;
    days_o     <= days_d;
    rsec_o     <= {rem_d, lo_q};
    res_o      <= res_q;
  end

endmodule

/* rtl/ctau_cal.sv */
// ----------------------------------------------------------------------------
// Calendar date split
// Year and month search over the tables, and the time of day split.
// ----------------------------------------------------------------------------
module ctau_cal import ctau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        use_conv_i,
  input  logic [15:0] days_i,
  input  logic [16:0] rsec_i,
  input  result_t     res_i,
  output logic        valid_o,
  output logic        use_conv_o,
  output result_t     conv_o,
  output result_t     res_o
);

  // Stage A: year search and hour estimate.
  logic [Years-1:0] above;
  logic [YidxW-1:0] yidx;
  logic [15:0]      ystart;
  logic [6:0]       yr_d;
  logic             found_d;
  logic             oor_d;
  logic             leap_d;
  logic [8:0]       doy_d;
  logic [34:0]      hprod;
  logic [4:0]       hour_d;

  always_comb begin
    above  = '0;
    yidx   = '0;
    ystart = '0;
    yr_d   = '0;
    for (int i = 0; i < Years; i++) begin
      above[i] = days_i > year_end(i);
      yidx     = yidx + YidxW'(above[i]);
    end
    for (int i = 0; i < Years; i++) begin
      if (yidx == YidxW'(i + 1)) begin
        ystart = year_end(i);
      end
      if (yidx == YidxW'(i)) begin
        yr_d = year_two_digit(i);
      end
    end
    found_d = (days_i != 16'd0) && !above[Years-1];
    oor_d   = (days_i != 16'd0) && above[Years-1];
    leap_d  = (yidx[1:0] == 2'd2);
    doy_d   = 9'(days_i - ystart);
    hprod   = 35'(rsec_i) * 35'(RecipHour);
    hour_d  = 5'(hprod >> RecipHourSh);
  end

  logic        va_q;
  logic        uca_q;
  logic        founda_q;
  logic        oora_q;
  logic        leapa_q;
  logic [6:0]  yra_q;
  logic [8:0]  doya_q;
  logic [16:0] rseca_q;
  logic [4:0]  houra_q;
  result_t     resa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    uca_q    <= use_conv_i;
    founda_q <= found_d;
    oora_q   <= oor_d;
    leapa_q  <= leap_d;
    yra_q    <= yr_d;
    doya_q   <= doy_d;
    rseca_q  <= rsec_i;
    houra_q  <= hour_d;
    resa_q   <= res_i;
  end

  // Stage B: month search and remainder within the hour.
  logic [3:0]  midx;
  logic [8:0]  mstart;
  logic [4:0]  dy_d;
  logic [11:0] rem_d;
  result_t     conv_d;

  always_comb begin
    midx   = '0;
    mstart = '0;
    for (int k = 1; k < 12; k++) begin
      if (doya_q > month_start(k, leapa_q)) begin
        midx = midx + 4'd1;
      end
    end
    for (int k = 0; k < 12; k++) begin
      if (midx == 4'(k)) begin
        mstart = month_start(k, leapa_q);
      end
    end
    dy_d  = 5'(doya_q - mstart);
    rem_d = 12'(rseca_q - 17'(houra_q) * 17'd3600);

    // The date is only given for a day count inside the table.
    conv_d       = '0;
    conv_d.year  = founda_q ? yra_q : 7'd0;
    conv_d.month = founda_q ? (midx + 4'd1) : 4'd0;
    conv_d.day   = founda_q ? dy_d : 5'd0;
    conv_d.hour  = houra_q;
    conv_d.oor   = oora_q;
  end

  logic        vb_q;
  logic        ucb_q;
  result_t     convb_q;
  logic [11:0] remb_q;
  result_t     resb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ucb_q   <= uca_q;
    convb_q <= conv_d;
    remb_q  <= rem_d;
    resb_q  <= resa_q;
  end

  // Stage C: minute estimate.
  logic        vc_q;
  logic        ucc_q;
  result_t     convc_q;
  logic [11:0] remc_q;
  logic [5:0]  minc_q;
  result_t     resc_q;
  logic [26:0] mprod;

  assign mprod = 27'(remb_q) * 27'(RecipMin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ucc_q   <= ucb_q;
    convc_q <= convb_q;
    remc_q  <= remb_q;
    minc_q  <= 6'(mprod >> RecipMinSh);
    resc_q  <= resb_q;
  end

  // Stage D: seconds and the finished date-time.
  result_t conv_fin;

  always_comb begin
    conv_fin        = convc_q;
    conv_fin.minute = minc_q;
    conv_fin.second = 6'(remc_q - 12'(minc_q) * 12'd60);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    use_conv_o <= ucc_q;
    conv_o     <= conv_fin;
    res_o      <= resc_q;
  end

  // A date is only given for a day count inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && !founda_q |=> convb_q.month == 4'd0 && convb_q.day == 5'd0)
    else $error("date given for a count outside the table");

  // A day count is never both inside and beyond the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> !(founda_q && oora_q))
    else $error("day count both found and out of range");

  // The hour of a seconds remainder is always below a full day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> houra_q < 5'd24)
    else $error("hour estimate beyond one day");

endmodule

/* rtl/calendar_time_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Calendar time arithmetic unit
// Date-time counts, seconds to date conversion and interval arithmetic.
// The result strobe rises once an item has passed the front end, day split, date split and result register.
// Throughput: one item every cycle; busy_o is always low.
// Every item gives exactly one result, shown for one cycle on valid_o.
// Reset clears the pipeline valid bits only; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module calendar_time_arithmetic_unit import ctau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  second_in_i,
  input  logic [2:0]  unit_i,
  input  logic [31:0] amount_i,
  output logic        valid_o,
  output logic [6:0]  year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [31:0] count_out_o,
  output logic        out_of_range_o
);

  logic        f_valid;
  logic        f_uc;
  logic [31:0] f_total;
  result_t     f_res;

  logic        d_valid;
  logic        d_uc;
  logic [15:0] d_days;
  logic [16:0] d_rsec;
  result_t     d_res;

  logic        c_valid;
  logic        c_uc;
  result_t     c_conv;
  result_t     c_res;

  assign busy_o = 1'b0;

  ctau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .year_i     (year_in_i),
    .month_i    (month_in_i),
    .day_i      (day_in_i),
    .hour_i     (hour_in_i),
    .minute_i   (minute_in_i),
    .second_i   (second_in_i),
    .unit_i     (unit_i),
    .amount_i   (amount_i),
    .valid_o    (f_valid),
    .use_conv_o (f_uc),
    .total_o    (f_total),
    .res_o      (f_res)
  );

  ctau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (f_valid),
    .use_conv_i (f_uc),
    .total_i    (f_total),
    .res_i      (f_res),
    .valid_o    (d_valid),
    .use_conv_o (d_uc),
    .days_o     (d_days),
    .rsec_o     (d_rsec),
    .res_o      (d_res)
  );

  ctau_cal u_cal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d_valid),
    .use_conv_i (d_uc),
    .days_i     (d_days),
    .rsec_i     (d_rsec),
    .res_i      (d_res),
    .valid_o    (c_valid),
    .use_conv_o (c_uc),
    .conv_o     (c_conv),
    .res_o      (c_res)
  );

  // Result register: converted date-time or the direct result.
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= c_uc ? c_conv : c_res;
  end

  assign year_out_o     = out_q.year;
  assign month_out_o    = out_q.month;
  assign day_out_o      = out_q.day;
  assign hour_out_o     = out_q.hour;
  assign minute_out_o   = out_q.minute;
  assign second_out_o   = out_q.second;
  assign count_out_o    = out_q.count;
  assign out_of_range_o = out_q.oor;

  // An out of range result carries no date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_of_range_o |->
      year_out_o == 7'd0 && month_out_o == 4'd0 && day_out_o == 5'd0)
    else $error("out of range result carries a date");

  // Only count results carry a count, and those have no flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && count_out_o != 32'd0 |-> !out_of_range_o && year_out_o == 7'd0)
    else $error("count mixed with a date result");

  // The strobe follows the pipeline valid chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid |=> valid_o)
    else $error("result strobe lost");

endmodule
